// ===== design/tvs_pkg.sv =====
package tvs_pkg;

  // Fixed field widths of the ports
  localparam int POS_W      = 16;
  localparam int STRIDE_W   = 17;
  localparam int WADDR_W    = 16;
  localparam int WDATA_W    = 8;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 2;

  // Wide enough to compare any write address against any allowed depth
  localparam int WCMP_W     = 25;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_STRIDE = 2'd1;

  // Request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST   = 17'd256;
  localparam logic [STRIDE_W-1:0] SLICE_STRIDE_RST = 17'd65536;

  localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

  // Corner read issued to the memory: bit 2 = x+1, bit 1 = y+1, bit 0 = z+1
  typedef struct packed {
    logic       vld;
    logic [2:0] corner;
  } rd_ctl_t;

endpackage

// ===== design/tvs_vol_mem.sv =====
module tvs_vol_mem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/tvs_addr_gen.sv =====
module tvs_addr_gen #(
  parameter int VOL_DEPTH = 65536,
  parameter int FRAC_BITS = 8,
  parameter int ADDR_W    = 16
) (
  input  logic                          clk,
  input  logic [tvs_pkg::POS_W-1:0]    pos_x,
  input  logic [tvs_pkg::POS_W-1:0]    pos_y,
  input  logic [tvs_pkg::POS_W-1:0]    pos_z,
  input  logic [tvs_pkg::STRIDE_W-1:0] row_stride,
  input  logic [tvs_pkg::STRIDE_W-1:0] slice_stride,
  input  logic [2:0]                   corner,
  output logic [ADDR_W-1:0]            corner_addr,
  output logic                         beyond
);

  localparam int PROD_W = tvs_pkg::POS_W + tvs_pkg::STRIDE_W;
  localparam int SUM_W  = PROD_W + 3;

  logic [tvs_pkg::POS_W-1:0] ix;
  logic [tvs_pkg::POS_W-1:0] iy;
  logic [tvs_pkg::POS_W-1:0] iz;
  logic [tvs_pkg::POS_W-1:0] ix_q;
  logic [PROD_W-1:0]         prod_y;
  logic [PROD_W-1:0]         prod_z;
  logic [SUM_W-1:0]          base_next;
  logic [SUM_W-1:0]          far_next;
  logic [SUM_W-1:0]          base;

  assign ix = pos_x >> FRAC_BITS;
  assign iy = pos_y >> FRAC_BITS;
  assign iz = pos_z >> FRAC_BITS;

  // Stage 1: row and slice offsets of the low corner
  always_ff @(posedge clk) begin
    prod_y <= PROD_W'(iy) * PROD_W'(row_stride);
    prod_z <= PROD_W'(iz) * PROD_W'(slice_stride);
    ix_q   <= ix;
  end

  // The all-high corner has the largest address: it alone decides range
  assign base_next = SUM_W'(ix_q) + SUM_W'(prod_y) + SUM_W'(prod_z);
  assign far_next  = base_next + SUM_W'(1) + SUM_W'(row_stride) + SUM_W'(slice_stride);

  // Stage 2: base address and range flag
  always_ff @(posedge clk) begin
    base   <= base_next;
    beyond <= far_next >= SUM_W'(VOL_DEPTH);
  end

  // Corner addresses stay below the depth once the range check passed
  assign corner_addr = base[ADDR_W-1:0] + ADDR_W'(corner[2])
                     + (corner[1] ? ADDR_W'(row_stride)   : {ADDR_W{1'b0}})
                     + (corner[0] ? ADDR_W'(slice_stride) : {ADDR_W{1'b0}});

endmodule

// ===== design/tvs_interp.sv =====
module tvs_interp #(
  parameter int FRAC_BITS    = 8,
  parameter int SAMPLE_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tvs_pkg::rd_ctl_t           rd,
  input  logic [SAMPLE_WIDTH-1:0]    rdata,
  input  logic [FRAC_BITS-1:0]       frac_x,
  input  logic [FRAC_BITS-1:0]       frac_y,
  input  logic [FRAC_BITS-1:0]       frac_z,
  output logic                       done,
  output logic [tvs_pkg::OUT_W-1:0]  value
);

  localparam int WGT_W = FRAC_BITS + 1;
  localparam int ZW    = SAMPLE_WIDTH + FRAC_BITS;
  localparam int YW    = SAMPLE_WIDTH + 2 * FRAC_BITS;
  localparam int XW    = SAMPLE_WIDTH + 3 * FRAC_BITS;
  localparam int CMP_W = (XW > tvs_pkg::OUT_W) ? XW : tvs_pkg::OUT_W;
  localparam logic [WGT_W-1:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};

  logic [WGT_W-1:0] wz;
  logic [WGT_W-1:0] wy;
  logic [WGT_W-1:0] wx;

  // Pipeline valid and corner tags
  logic       v1, v2, v3, v4, v5, v6;
  logic [2:0] k1, k2;
  logic [1:0] k3, k4;
  logic       k5, k6;

  logic [ZW-1:0] zprod, zlo, zsum;
  logic [YW-1:0] yprod, ylo, ysum;
  logic [XW-1:0] xprod, xlo, xsum;
  logic [XW-1:0] shifted;

  assign wz = k1[0] ? {1'b0, frac_z} : ONE_W - {1'b0, frac_z};
  assign wy = k3[0] ? {1'b0, frac_y} : ONE_W - {1'b0, frac_y};
  assign wx = k5    ? {1'b0, frac_x} : ONE_W - {1'b0, frac_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= rd.vld;
      v2   <= v1;
      v3   <= v2 & k2[0];
      v4   <= v3;
      v5   <= v4 & k4[0];
      v6   <= v5;
      done <= v6 & k6;
    end
  end

  always_ff @(posedge clk) begin
    // align the tag with the registered memory output
    k1 <= rd.corner;
    // z weight
    zprod <= ZW'(rdata) * ZW'(wz);
    k2    <= k1;
    // pair along z
    if (v2) begin
      if (!k2[0]) begin
        zlo <= zprod;
      end else begin
        zsum <= zlo + zprod;
      end
    end
    k3 <= k2[2:1];
    // y weight
    yprod <= YW'(zsum) * YW'(wy);
    k4    <= k3;
    if (v4) begin
      if (!k4[0]) begin
        ylo <= yprod;
      end else begin
        ysum <= ylo + yprod;
      end
    end
    k5 <= k4[1];
    // x weight
    xprod <= XW'(ysum) * XW'(wx);
    k6    <= k5;
    if (v6) begin
      if (!k6) begin
        xlo <= xprod;
      end else begin
        xsum <= xlo + xprod;
      end
    end
  end

  // Drop 2*FRAC_BITS of the weight fraction bits (FRAC_BITS remain), clip to the result field
  assign shifted = xsum >> (2 * FRAC_BITS);
  assign value = (CMP_W'(shifted) > CMP_W'(tvs_pkg::OUT_MAX)) ?
                 tvs_pkg::OUT_MAX : tvs_pkg::OUT_W'(shifted);

endmodule

// ===== design/trilinear_volume_sampler.sv =====
// Channel | Direction | Handshake                 | Word
// in      | input     | in_valid / in_ready       | req_type, write_addr, write_data, pos_x/y/z
// out     | output    | out_valid / out_ready     | interp_value, out_of_range
// cfg     | input     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One word in flight. A write goes from accept straight to the hand-off; an
// out-of-range sample goes through the address multiply and range check; a
// sample goes through those, eight corner reads through the single memory
// port, the drain of the z/y/x weighting pipeline and the hand-off. Synchronous
// reset clears control and strides, not the volume memory. A result waits in the
// output register while the next word is accepted; a stalled output holds the block in FIN.
module trilinear_volume_sampler #(
  parameter int VOL_DEPTH    = 65536,
  parameter int FRAC_BITS    = 8,
  parameter int SAMPLE_WIDTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [tvs_pkg::WADDR_W-1:0]   write_addr,
  input  logic [tvs_pkg::WDATA_W-1:0]   write_data,
  input  logic [tvs_pkg::POS_W-1:0]     pos_x,
  input  logic [tvs_pkg::POS_W-1:0]     pos_y,
  input  logic [tvs_pkg::POS_W-1:0]     pos_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tvs_pkg::OUT_W-1:0]     interp_value,
  output logic                           out_of_range,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tvs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvs_pkg::STRIDE_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(VOL_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]                     state;
  logic [2:0]                     corner;
  logic [tvs_pkg::STRIDE_W-1:0]  row_stride;
  logic [tvs_pkg::STRIDE_W-1:0]  slice_stride;
  logic [tvs_pkg::POS_W-1:0]     px;
  logic [tvs_pkg::POS_W-1:0]     py;
  logic [tvs_pkg::POS_W-1:0]     pz;
  logic [tvs_pkg::OUT_W-1:0]     res_value;
  logic                           res_oor;

  logic                           in_fire;
  logic                           wr_in_range;
  logic                           mem_we;
  logic [ADDR_W-1:0]              mem_addr;
  logic [ADDR_W-1:0]              corner_addr;
  logic [SAMPLE_WIDTH-1:0]        rdata;
  logic                           beyond;
  logic                           done;
  logic [tvs_pkg::OUT_W-1:0]     value;
  logic                           out_load;
  tvs_pkg::rd_ctl_t               rd;

  // Refuse words and register writes while reset is held
  assign in_ready    = (state == ST_IDLE) && !rst;
  assign in_fire     = in_valid && in_ready;
  assign cfg_ready   = !rst;
  assign wr_in_range = tvs_pkg::WCMP_W'(write_addr) < tvs_pkg::WCMP_W'(VOL_DEPTH);

  // Writes go straight to memory on accept; an address past the depth is dropped
  assign mem_we   = in_fire && (req_type == tvs_pkg::REQ_WRITE) && wr_in_range;
  assign mem_addr = (state == ST_IDLE) ? ADDR_W'(write_addr) : corner_addr;

  assign rd.vld    = (state == ST_READ);
  assign rd.corner = corner;

  assign out_load = (state == ST_FIN) && (!out_valid || out_ready);

  // Stride registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride   <= tvs_pkg::ROW_STRIDE_RST;
      slice_stride <= tvs_pkg::SLICE_STRIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tvs_pkg::CFG_ROW_STRIDE:   row_stride   <= cfg_data;
        tvs_pkg::CFG_SLICE_STRIDE: slice_stride <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      corner <= 3'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= (req_type == tvs_pkg::REQ_SAMPLE) ? ST_MUL : ST_FIN;
          end
        end
        ST_MUL: state <= ST_SUM;
        ST_SUM: state <= ST_CHK;
        ST_CHK: begin
          corner <= 3'd0;
          state  <= beyond ? ST_FIN : ST_READ;
        end
        ST_READ: begin
          // one corner per cycle through the single port
          corner <= corner + 3'd1;
          if (corner == 3'd7) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Held word fields and the pending result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      px        <= pos_x;
      py        <= pos_y;
      pz        <= pos_z;
      res_value <= '0;
      res_oor   <= 1'b0;
    end
    if (state == ST_CHK && beyond) begin
      res_value <= '0;
      res_oor   <= 1'b1;
    end
    if (state == ST_DRAIN && done) begin
      res_value <= value;
      res_oor   <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      interp_value <= res_value;
      out_of_range <= res_oor;
    end
  end

  tvs_vol_mem #(
    .DEPTH  (VOL_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (SAMPLE_WIDTH'(write_data)),
    .rdata (rdata)
  );

  tvs_addr_gen #(
    .VOL_DEPTH (VOL_DEPTH),
    .FRAC_BITS (FRAC_BITS),
    .ADDR_W    (ADDR_W)
  ) u_addr (
    .clk          (clk),
    .pos_x        (px),
    .pos_y        (py),
    .pos_z        (pz),
    .row_stride   (row_stride),
    .slice_stride (slice_stride),
    .corner       (corner),
    .corner_addr  (corner_addr),
    .beyond       (beyond)
  );

  tvs_interp #(
    .FRAC_BITS    (FRAC_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_interp (
    .clk    (clk),
    .rst    (rst),
    .rd     (rd),
    .rdata  (rdata),
    .frac_x (px[FRAC_BITS-1:0]),
    .frac_y (py[FRAC_BITS-1:0]),
    .frac_z (pz[FRAC_BITS-1:0]),
    .done   (done),
    .value  (value)
  );

  // The weighting pipeline finishes only while the sequencer waits for it
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_DRAIN))
    else $error("interpolation finished outside drain");

  // No corner read once the range check failed
  a_no_read_beyond: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !beyond)
    else $error("corner read on out-of-range sample");

  // Out-of-range results carry a zero value
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (interp_value == '0))
    else $error("out-of-range result with nonzero value");

  // Corner reads start at the low corner
  a_read_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK && !beyond) |=> (state == ST_READ && corner == 3'd0))
    else $error("corner sequence did not start at corner zero");

endmodule

// ===== bench/tb_trilinear_volume_sampler.sv =====
module tb_trilinear_volume_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  // Block parameters, kept at their defaults
  localparam int VOL_DEPTH    = 65536;
  localparam int FRAC_BITS    = 8;
  localparam int SAMPLE_WIDTH = 8;

  localparam longint unsigned ONE_FIX = 64'd1 << FRAC_BITS;

  // Register indexes past the end of the list; writes to them must do nothing
  localparam logic [tvs_pkg::CFG_IDX_W-1:0] CFG_NO_REG_LO = 2'd2;
  localparam logic [tvs_pkg::CFG_IDX_W-1:0] CFG_NO_REG_HI = 2'd3;

  // Idle schedule: receiver-heavy, then sender-heavy, then no idling at all
  localparam int SWAP_AT  = 550;
  localparam int QUIET_AT = 1100;

  // Cell span around the origin that most sample words aim at
  localparam int NEAR_SPAN = 4;

  localparam int RESET_CYCLES   = 12;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  // One input word, as the block sees it on its ports
  typedef struct packed {
    logic                          req;
    logic [tvs_pkg::WADDR_W-1:0]   waddr;
    logic [tvs_pkg::WDATA_W-1:0]   wdata;
    logic [tvs_pkg::POS_W-1:0]     px;
    logic [tvs_pkg::POS_W-1:0]     py;
    logic [tvs_pkg::POS_W-1:0]     pz;
  } vol_word_t;

  // One result word
  typedef struct packed {
    logic [tvs_pkg::OUT_W-1:0] value;
    logic                      oor;
  } sample_t;

  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

  // One line of the directed stimulus
  typedef struct {
    row_kind_t                      kind;
    logic [tvs_pkg::CFG_IDX_W-1:0]  idx;
    logic [tvs_pkg::STRIDE_W-1:0]   val;
    vol_word_t                      w;
    bit                             typed;
    sample_t                        want;
  } stim_row_t;

  localparam sample_t QUIET_RESULT   = '{value: 16'h0000, oor: 1'b0};
  localparam sample_t OUTSIDE_RESULT = '{value: 16'h0000, oor: 1'b1};
  localparam sample_t FULL_SCALE     = '{value: 16'hFF00, oor: 1'b0};

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic                           req_type;
  logic [tvs_pkg::WADDR_W-1:0]    write_addr;
  logic [tvs_pkg::WDATA_W-1:0]    write_data;
  logic [tvs_pkg::POS_W-1:0]      pos_x;
  logic [tvs_pkg::POS_W-1:0]      pos_y;
  logic [tvs_pkg::POS_W-1:0]      pos_z;
  logic                           out_valid;
  logic                           out_ready;
  logic [tvs_pkg::OUT_W-1:0]      interp_value;
  logic                           out_of_range;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tvs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tvs_pkg::STRIDE_W-1:0]   cfg_data;

  // Shadow of the volume memory and of the stride registers
  logic [tvs_pkg::WDATA_W-1:0]    vol_mem [VOL_DEPTH];
  bit                             vol_filled [VOL_DEPTH];
  logic [tvs_pkg::STRIDE_W-1:0]   row_step   = tvs_pkg::ROW_STRIDE_RST;
  logic [tvs_pkg::STRIDE_W-1:0]   slice_step = tvs_pkg::SLICE_STRIDE_RST;

  // Results still owed by the block, oldest first
  sample_t expected_samples[$];

  // Directed stimulus table
  stim_row_t dir_rows[$];

  int send_idle_pct = 37;
  int recv_idle_pct = 61;

  int n_words;
  int n_writes;
  int n_interps;
  int n_outside;
  int n_reg_writes;
  int n_errors;

  trilinear_volume_sampler #(
    .VOL_DEPTH    (VOL_DEPTH),
    .FRAC_BITS    (FRAC_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .write_addr   (write_addr),
    .write_data   (write_data),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .interp_value (interp_value),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Append one result to the owed list
  function automatic void owe_result(input sample_t s);
    expected_samples.insert(expected_samples.size(), s);
  endfunction

  // Append one line to the directed table
  function automatic void add_row(input stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Address of corner k: bit 2 steps x, bit 1 steps y, bit 0 steps z.
  // Wide arithmetic so that oversized strides never wrap.
  function automatic longint unsigned corner_addr(input vol_word_t w, input int k);
    longint unsigned cx, cy, cz;
    cx = 64'(w.px >> FRAC_BITS);
    cy = 64'(w.py >> FRAC_BITS);
    cz = 64'(w.pz >> FRAC_BITS);
    cx += 64'((k >> 2) & 1);
    cy += 64'((k >> 1) & 1);
    cz += 64'(k & 1);
    return cx + cy * 64'(row_step) + cz * 64'(slice_step);
  endfunction

  // Work out the result of one word. A write lands in the shadow volume and
  // answers zero; a sample either flags a corner outside the memory or sums
  // the eight corners with exact integer weights and drops 2*FRAC_BITS bits.
  function automatic sample_t interpolate_word(input vol_word_t w);
    sample_t         r;
    longint unsigned acc, wt, a, fx, fy, fz, samp;
    bit              outside;
    int              k;
    r = QUIET_RESULT;
    if (w.req == tvs_pkg::REQ_WRITE) begin
      vol_mem[w.waddr]    = w.wdata;
      vol_filled[w.waddr] = 1'b1;
      return r;
    end
    outside = 1'b0;
    for (k = 0; k < 8; k++) begin
      if (corner_addr(w, k) >= 64'(VOL_DEPTH)) outside = 1'b1;
    end
    // No corner is read when any of them falls outside
    if (outside) begin
      r.oor = 1'b1;
      return r;
    end
    fx  = 64'(w.px[FRAC_BITS-1:0]);
    fy  = 64'(w.py[FRAC_BITS-1:0]);
    fz  = 64'(w.pz[FRAC_BITS-1:0]);
    acc = 0;
    for (k = 0; k < 8; k++) begin
      a    = corner_addr(w, k);
      wt   = (((k & 4) != 0) ? fx : ONE_FIX - fx)
           * (((k & 2) != 0) ? fy : ONE_FIX - fy)
           * (((k & 1) != 0) ? fz : ONE_FIX - fz);
      samp = 64'(vol_mem[a[tvs_pkg::WADDR_W-1:0]]);
      acc += samp * wt;
    end
    acc     = acc >> (2 * FRAC_BITS);
    r.value = (acc > 64'(tvs_pkg::OUT_MAX)) ? tvs_pkg::OUT_MAX : acc[tvs_pkg::OUT_W-1:0];
    return r;
  endfunction

  // Drive one word, hold it until taken, then queue what it should produce.
  // Typed rows supply their own expectation; the shadow model still sees them.
  task automatic send_word(input vol_word_t w, input bit typed, input sample_t want);
    sample_t predicted;
    // Swap which side stalls, then stop stalling altogether
    if (n_words == SWAP_AT) begin
      send_idle_pct = 61;
      recv_idle_pct = 37;
    end else if (n_words == QUIET_AT) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= w.req;
    write_addr <= w.waddr;
    write_data <= w.wdata;
    pos_x      <= w.px;
    pos_y      <= w.py;
    pos_z      <= w.pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = interpolate_word(w);
    owe_result(typed ? want : predicted);
    n_words++;
    if (w.req == tvs_pkg::REQ_WRITE) n_writes++;
    else n_interps++;
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  // Write one register with the block idle; unknown indexes leave the strides alone
  task automatic set_register(input logic [tvs_pkg::CFG_IDX_W-1:0] idx,
                              input logic [tvs_pkg::STRIDE_W-1:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == tvs_pkg::CFG_ROW_STRIDE) row_step = val;
    else if (idx == tvs_pkg::CFG_SLICE_STRIDE) slice_step = val;
    n_reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random word. Most are samples near the origin; any corner not yet
  // written gets a write first, so the block never reads an empty entry.
  // The rest are stray writes and samples anywhere in the position range.
  task automatic random_word();
    vol_word_t       w, fill;
    int              pick, k;
    longint unsigned a;
    bit              in_vol;
    logic [7:0]      cx, cy, cz;
    w.req   = tvs_pkg::REQ_SAMPLE;
    w.waddr = 16'($urandom);
    w.wdata = 8'($urandom);
    w.px    = 16'($urandom);
    w.py    = 16'($urandom);
    w.pz    = 16'($urandom);
    pick    = int'($urandom_range(0, 99));
    if (pick < 15) begin
      w.req = tvs_pkg::REQ_WRITE;
      // Half the stray writes overwrite the busy corner of the volume
      if (pick < 8) w.waddr = 16'($urandom_range(0, 1023));
      send_word(w, 1'b0, QUIET_RESULT);
    end else begin
      if (pick >= 25) begin
        cx   = 8'($urandom_range(0, NEAR_SPAN));
        cy   = 8'($urandom_range(0, NEAR_SPAN));
        cz   = 8'($urandom_range(0, NEAR_SPAN));
        w.px = {cx, w.px[FRAC_BITS-1:0]};
        w.py = {cy, w.py[FRAC_BITS-1:0]};
        w.pz = {cz, w.pz[FRAC_BITS-1:0]};
      end
      in_vol = 1'b1;
      for (k = 0; k < 8; k++) begin
        if (corner_addr(w, k) >= 64'(VOL_DEPTH)) in_vol = 1'b0;
      end
      if (in_vol) begin
        for (k = 0; k < 8; k++) begin
          a = corner_addr(w, k);
          if (!vol_filled[a[tvs_pkg::WADDR_W-1:0]]) begin
            fill       = w;
            fill.req   = tvs_pkg::REQ_WRITE;
            fill.waddr = a[tvs_pkg::WADDR_W-1:0];
            fill.wdata = 8'($urandom);
            send_word(fill, 1'b0, QUIET_RESULT);
          end
        end
      end
      send_word(w, 1'b0, QUIET_RESULT);
    end
  endtask

  // Set both strides, then run random words until the phase has its share
  task automatic run_phase(input logic [tvs_pkg::STRIDE_W-1:0] row,
                           input logic [tvs_pkg::STRIDE_W-1:0] slice,
                           input int count);
    int first;
    set_register(tvs_pkg::CFG_ROW_STRIDE, row);
    set_register(tvs_pkg::CFG_SLICE_STRIDE, slice);
    first = n_words;
    while (n_words - first < count) random_word();
  endtask

  function automatic stim_row_t word_row(input logic req,
                                         input logic [tvs_pkg::WADDR_W-1:0] addr,
                                         input logic [tvs_pkg::WDATA_W-1:0] data,
                                         input logic [tvs_pkg::POS_W-1:0] x,
                                         input logic [tvs_pkg::POS_W-1:0] y,
                                         input logic [tvs_pkg::POS_W-1:0] z,
                                         input bit typed, input sample_t want);
    stim_row_t r;
    r.kind  = ROW_WORD;
    r.idx   = tvs_pkg::CFG_ROW_STRIDE;
    r.val   = '0;
    r.w     = '{req: req, waddr: addr, wdata: data, px: x, py: y, pz: z};
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [tvs_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [tvs_pkg::STRIDE_W-1:0] val);
    stim_row_t r;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.val   = val;
    r.w     = '0;
    r.typed = 1'b0;
    r.want  = QUIET_RESULT;
    return r;
  endfunction

  // Receiver: take results at random, compare each with the oldest expectation
  initial begin
    sample_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: result with nothing owed: interp_value %h out_of_range %b",
                   $time, interp_value, out_of_range);
          n_errors++;
        end else begin
          want = expected_samples.pop_front();
          if (interp_value !== want.value) begin
            $display("%0t: interp_value expected %h, got %h", $time, want.value, interp_value);
            n_errors++;
          end
          if (out_of_range !== want.oor) begin
            $display("%0t: out_of_range expected %b, got %b", $time, want.oor, out_of_range);
            n_errors++;
          end
          if (want.oor) n_outside++;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int i;

    // Reset strides: every z+1 corner lies past the memory
    add_row(word_row(tvs_pkg::REQ_SAMPLE, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                     1'b1, OUTSIDE_RESULT));
    // Write extremes of address and data
    add_row(word_row(tvs_pkg::REQ_WRITE, 16'h0000, 8'hFF, 16'hFFFF, 16'h0000, 16'hFFFF,
                     1'b1, QUIET_RESULT));
    add_row(word_row(tvs_pkg::REQ_WRITE, 16'hFFFF, 8'h00, 16'h0000, 16'hFFFF, 16'h0000,
                     1'b1, QUIET_RESULT));
    add_row(word_row(tvs_pkg::REQ_SAMPLE, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     1'b1, OUTSIDE_RESULT));
    // Tiny 2x2x2 volume at the origin; writes past the list must not touch it
    add_row(cfg_row(tvs_pkg::CFG_ROW_STRIDE, 17'd2));
    add_row(cfg_row(tvs_pkg::CFG_SLICE_STRIDE, 17'd4));
    add_row(cfg_row(CFG_NO_REG_LO, 17'h1FFFF));
    add_row(cfg_row(CFG_NO_REG_HI, 17'h00000));
    add_row(word_row(tvs_pkg::REQ_WRITE, 16'd1, 8'h80, 16'h1234, 16'h5678, 16'h9ABC,
                     1'b1, QUIET_RESULT));
    add_row(word_row(tvs_pkg::REQ_WRITE, 16'd2, 8'h01, 16'h0000, 16'h0000, 16'h0000,
                     1'b1, QUIET_RESULT));
    add_row(word_row(tvs_pkg::REQ_WRITE, 16'd3, 8'hFE, 16'h0000, 16'h0000, 16'h0000,
                     1'b1, QUIET_RESULT));
    add_row(word_row(tvs_pkg::REQ_WRITE, 16'd4, 8'h40, 16'h0000, 16'h0000, 16'h0000,
                     1'b1, QUIET_RESULT));
    add_row(word_row(tvs_pkg::REQ_WRITE, 16'd5, 8'h7F, 16'h0000, 16'h0000, 16'h0000,
                     1'b1, QUIET_RESULT));
    add_row(word_row(tvs_pkg::REQ_WRITE, 16'd6, 8'hC3, 16'h0000, 16'h0000, 16'h0000,
                     1'b1, QUIET_RESULT));
    add_row(word_row(tvs_pkg::REQ_WRITE, 16'd7, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                     1'b1, QUIET_RESULT));
    // Whole weight on the 0xFF corner gives the largest result
    add_row(word_row(tvs_pkg::REQ_SAMPLE, 16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                     1'b1, FULL_SCALE));
    add_row(word_row(tvs_pkg::REQ_SAMPLE, 16'h0000, 8'h00, 16'h00FF, 16'h00FF, 16'h00FF,
                     1'b0, QUIET_RESULT));
    add_row(word_row(tvs_pkg::REQ_SAMPLE, 16'h0000, 8'h00, 16'h0080, 16'h0040, 16'h00C0,
                     1'b0, QUIET_RESULT));
    // Zero strides fold y and z away, so even the top of the range stays inside
    add_row(cfg_row(tvs_pkg::CFG_ROW_STRIDE, 17'd0));
    add_row(cfg_row(tvs_pkg::CFG_SLICE_STRIDE, 17'd0));
    add_row(word_row(tvs_pkg::REQ_SAMPLE, 16'h0000, 8'h00, 16'h00AA, 16'hFFFF, 16'hFFFF,
                     1'b0, QUIET_RESULT));
    add_row(word_row(tvs_pkg::REQ_SAMPLE, 16'h0000, 8'h00, 16'h0001, 16'hFFFF, 16'h8000,
                     1'b0, QUIET_RESULT));

    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= tvs_pkg::REQ_WRITE;
    write_addr <= '0;
    write_data <= '0;
    pos_x      <= '0;
    pos_y      <= '0;
    pos_z      <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= tvs_pkg::CFG_ROW_STRIDE;
    cfg_data   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part: registers are written only once the block has drained
    for (i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].kind == ROW_CFG) set_register(dir_rows[i].idx, dir_rows[i].val);
      else send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part, one stride setting per phase: ordinary volumes, overlapping
    // corners, zero strides, the upper extremes, all-ones and random strides
    run_phase(17'd6, 17'd36, 300);
    run_phase(17'd1, 17'd1, 220);
    run_phase(17'd0, 17'd0, 160);
    run_phase(17'd65536, 17'd1, 60);
    run_phase(17'd1, 17'd65536, 60);
    run_phase(17'h1FFFF, 17'h1FFFF, 60);
    run_phase(17'($urandom_range(1, 64)), 17'($urandom_range(1, 4096)), 400);
    run_phase(17'd16, 17'd300, 330);

    // Let the last results come home, then give any stray output time to show
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d words: %0d writes, %0d interpolations, %0d of them outside",
             n_words, n_writes, n_interps, n_outside);
    $display("across %0d register writes and three stall patterns; %0d mismatches",
             n_reg_writes, n_errors);
    if (n_errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
